FILE: rtl/bkvt_pkg.sv
// bkvt_pkg: shared constants and operation codes for the bucketed key/value table.
// Used by bkvt_fill_store and bucketed_key_value_table; depends on nothing.
package bkvt_pkg;

    // Default geometry
    localparam int BUCKETS_DEF = 1024;
    localparam int WAYS_DEF    = 8;

    // Field widths of one beat
    localparam int KIND_W   = 2;
    localparam int BUCKET_W = 10;
    localparam int KEY_W    = 48;
    localparam int ID_W     = 32;

    // Operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_UPDATE = 2'd3
    } kind_t;

endpackage

FILE: rtl/bkvt_fill_store.sv
// bkvt_fill_store: per-bucket fill count memory with a clearing pass after reset.
// Depends on bkvt_pkg for default geometry.
module bkvt_fill_store #(
    parameter int BUCKETS = bkvt_pkg::BUCKETS_DEF,
    parameter int WAYS    = bkvt_pkg::WAYS_DEF,
    localparam int BIDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int FILL_W = $clog2(WAYS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BIDX_W-1:0] rd_addr,
    output logic [FILL_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [BIDX_W-1:0] wr_addr,
    input  logic [FILL_W-1:0] wr_data,
    output logic              ready
);

    localparam logic [BIDX_W-1:0] LAST_BUCKET = BIDX_W'(BUCKETS - 1);

    logic [FILL_W-1:0] fill_mem [BUCKETS];
    logic [FILL_W-1:0] rd_data_reg;
    logic [BIDX_W-1:0] clr_cnt_reg;
    logic [BIDX_W-1:0] clr_cnt_next;
    logic              clr_reg;
    logic              clr_next;
    logic              we;
    logic [BIDX_W-1:0] wa;
    logic [FILL_W-1:0] wd;

    // Sweep every bucket to zero once after reset
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        clr_next     = clr_reg;
        if (clr_reg)
        begin
            if (clr_cnt_reg == LAST_BUCKET)
            begin
                clr_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            clr_reg     <= 1'b1;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            clr_reg     <= clr_next;
        end
    end

    // Select the clearing sweep or the user write
    assign we = clr_reg | wr_en;
    assign wa = clr_reg ? clr_cnt_reg : wr_addr;
    assign wd = clr_reg ? '0 : wr_data;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            fill_mem[wa] <= wd;
        end
        rd_data_reg <= fill_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign ready   = ~clr_reg;

endmodule

FILE: rtl/bucketed_key_value_table.sv
// bucketed_key_value_table: top level, sequencer and entry memory of the table.
// Depends on bkvt_pkg and bkvt_fill_store.
//
// Each bucket holds up to WAYS (key, id) entries in arrival order. A command
// beat is taken when start is high and busy is low; exactly one result beat
// follows, shown for one cycle with done high, and it cannot be held off.
// One key comparator walks the bucket one way at a time. A command first
// fetches the fill count (subtracting BUCKETS while the bucket index is out
// of range). An insert then appends at once, without a search; the others
// read each way from the entry memory and then compare it. At the end of
// the bucket a miss is reported, but an update appends. A hit ends with its
// compare, except a delete, which reads and writes each later entry one way
// down to close the gap, then writes back the fill count. The result appears
// the cycle after the last step, and busy falls with it. After reset the
// fill counts are cleared one bucket a cycle; busy stays high meanwhile.
module bucketed_key_value_table #(
    parameter int BUCKETS = bkvt_pkg::BUCKETS_DEF,
    parameter int WAYS    = bkvt_pkg::WAYS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bkvt_pkg::KIND_W-1:0]   kind,
    input  logic [bkvt_pkg::BUCKET_W-1:0] bucket,
    input  logic [bkvt_pkg::KEY_W-1:0]    key,
    input  logic [bkvt_pkg::ID_W-1:0]     new_id,
    output logic                          done,
    output logic                          found,
    output logic [bkvt_pkg::ID_W-1:0]     old_id,
    output logic                          full_res
);

    localparam int BIDX_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W    = $clog2(WAYS + 1);
    localparam int ENT_DEPTH = BUCKETS * (2 ** WAY_W);
    localparam int ENT_W     = BIDX_W + WAY_W;
    localparam int KEY_W     = bkvt_pkg::KEY_W;
    localparam int ID_W      = bkvt_pkg::ID_W;
    localparam int BUCKET_W  = bkvt_pkg::BUCKET_W;

    localparam logic [FILL_W-1:0]   WAYS_F = FILL_W'(WAYS);
    localparam logic [BUCKET_W-1:0] B_STEP = BUCKET_W'(BUCKETS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_FILL,
        ST_SCAN,
        ST_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_APPEND
    } state_t;

    state_t                state_reg, state_next;
    bkvt_pkg::kind_t       kind_reg, kind_next;
    logic [BUCKET_W-1:0]   b_reg, b_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [ID_W-1:0]       nid_reg, nid_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [FILL_W-1:0]     way_reg, way_next;
    logic                  done_reg, done_next;
    logic                  found_reg, found_next;
    logic [ID_W-1:0]       old_reg, old_next;
    logic                  full_reg, full_next;

    logic [BIDX_W-1:0]     b_idx;
    logic [FILL_W-1:0]     way_inc;
    logic [FILL_W-1:0]     rd_way;
    logic                  ent_we;
    logic [FILL_W-1:0]     ent_wway;
    logic [KEY_W-1:0]      ent_wkey;
    logic [ID_W-1:0]       ent_wid;
    logic [KEY_W-1:0]      rd_key_reg;
    logic [ID_W-1:0]       rd_id_reg;
    logic                  fill_we;
    logic [FILL_W-1:0]     fill_wd;
    logic [FILL_W-1:0]     fill_rd;
    logic                  fill_ready;
    logic                  key_hit;

    logic [KEY_W-1:0]      key_mem [ENT_DEPTH];
    logic [ID_W-1:0]       id_mem  [ENT_DEPTH];

    assign b_idx   = BIDX_W'(b_reg);
    assign way_inc = way_reg + 1'b1;
    assign key_hit = (rd_key_reg == key_reg);

    // Fill counts with their clearing pass
    bkvt_fill_store #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_fill (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (b_idx),
        .rd_data (fill_rd),
        .wr_en   (fill_we),
        .wr_addr (b_idx),
        .wr_data (fill_wd),
        .ready   (fill_ready)
    );

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            key_mem[ENT_W'({b_idx, ent_wway[WAY_W-1:0]})] <= ent_wkey;
            id_mem[ENT_W'({b_idx, ent_wway[WAY_W-1:0]})]  <= ent_wid;
        end
        rd_key_reg <= key_mem[ENT_W'({b_idx, rd_way[WAY_W-1:0]})];
        rd_id_reg  <= id_mem[ENT_W'({b_idx, rd_way[WAY_W-1:0]})];
    end

    // Sequencer: walk the bucket one way at a time
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        b_next     = b_reg;
        key_next   = key_reg;
        nid_next   = nid_reg;
        fill_next  = fill_reg;
        way_next   = way_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        old_next   = old_reg;
        full_next  = full_reg;
        rd_way     = way_reg;
        ent_we     = 1'b0;
        ent_wway   = way_reg;
        ent_wkey   = key_reg;
        ent_wid    = nid_reg;
        fill_we    = 1'b0;
        fill_wd    = fill_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start && fill_ready)
                begin
                    kind_next  = bkvt_pkg::kind_t'(kind);
                    b_next     = bucket;
                    key_next   = key;
                    nid_next   = new_id;
                    state_next = ST_REDUCE;
                end
            end

            // Wrap the bucket index, then fetch its fill count
            ST_REDUCE:
            begin
                if (32'(b_reg) >= BUCKETS)
                begin
                    b_next = b_reg - B_STEP;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end

            ST_FILL:
            begin
                fill_next = fill_rd;
                way_next  = '0;
                if (kind_reg == bkvt_pkg::KIND_INSERT)
                begin
                    state_next = ST_APPEND;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            // Read the next way, or settle a miss
            ST_SCAN:
            begin
                if (way_reg == fill_reg)
                begin
                    if (kind_reg == bkvt_pkg::KIND_UPDATE)
                    begin
                        state_next = ST_APPEND;
                    end
                    else
                    begin
                        found_next = 1'b0;
                        old_next   = '0;
                        full_next  = 1'b0;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end

            // Compare the fetched way against the key
            ST_CMP:
            begin
                if (key_hit)
                begin
                    found_next = 1'b1;
                    old_next   = rd_id_reg;
                    full_next  = 1'b0;
                    case (kind_reg)
                        bkvt_pkg::KIND_DELETE:
                        begin
                            state_next = ST_SHIFT_RD;
                        end
                        bkvt_pkg::KIND_UPDATE:
                        begin
                            ent_we     = 1'b1;
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        default:
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
                else
                begin
                    way_next   = way_inc;
                    state_next = ST_SCAN;
                end
            end

            // Close the gap left by a delete
            ST_SHIFT_RD:
            begin
                if (way_inc < fill_reg)
                begin
                    rd_way     = way_inc;
                    state_next = ST_SHIFT_WR;
                end
                else
                begin
                    fill_we    = 1'b1;
                    fill_wd    = fill_reg - 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_SHIFT_WR:
            begin
                ent_we     = 1'b1;
                ent_wkey   = rd_key_reg;
                ent_wid    = rd_id_reg;
                way_next   = way_inc;
                state_next = ST_SHIFT_RD;
            end

            // Append at the tail, or refuse on a full bucket
            ST_APPEND:
            begin
                found_next = 1'b0;
                old_next   = '0;
                if (fill_reg >= WAYS_F)
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    full_next = 1'b0;
                    ent_we    = 1'b1;
                    ent_wway  = fill_reg;
                    fill_we   = 1'b1;
                    fill_wd   = fill_reg + 1'b1;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            old_reg   <= '0;
            full_reg  <= 1'b0;
            kind_reg  <= bkvt_pkg::KIND_LOOKUP;
            way_reg   <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            old_reg   <= old_next;
            full_reg  <= full_next;
            kind_reg  <= kind_next;
            way_reg   <= way_next;
            fill_reg  <= fill_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        b_reg   <= b_next;
        key_reg <= key_next;
        nid_reg <= nid_next;
    end

    assign busy     = (state_reg != ST_IDLE) || !fill_ready;
    assign done     = done_reg;
    assign found    = found_reg;
    assign old_id   = old_reg;
    assign full_res = full_reg;

    // A result beat never overlaps a command in flight
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // An accepted command keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without going busy");

    // A refused append never reports a match
    a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && full_res) |-> (!found && old_id == '0))
        else $error("full flag together with a match");

    // The compare step only looks at valid ways
    a_way_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (way_reg < fill_reg && fill_reg <= WAYS_F))
        else $error("compare beyond the bucket fill");

endmodule
